>>> sv/orthonormal_frame_from_axis_macros.svh
// Assertion macros for the orthonormal frame block.
// Included by the top level; depends on nothing else.
`ifndef ORTHONORMAL_FRAME_FROM_AXIS_MACROS_SVH
`define ORTHONORMAL_FRAME_FROM_AXIS_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define OFA_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
// Same-cycle implication.
`define OFA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define OFA_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define OFA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> sv/ofa_pkg.sv
// Shared constants, types and width helpers for the orthonormal frame block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ofa_pkg;

    localparam int IN_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF = 14;

    // Nine result components, each handled by its own lane.
    localparam int NLANE   = 9;
    localparam int LANE_UX = 0;
    localparam int LANE_UY = 1;
    localparam int LANE_UZ = 2;
    localparam int LANE_VX = 3;
    localparam int LANE_VY = 4;
    localparam int LANE_VZ = 5;
    localparam int LANE_WX = 6;
    localparam int LANE_WY = 7;
    localparam int LANE_WZ = 8;

    // Control that travels with each transaction down the pipeline.
    typedef struct packed {
        logic valid;
        logic zero;
    } ofa_ctl_t;

    // Width of the signed residual used by the rounding search.
    function automatic int acc_width(input int w, input int f);
        return 4 * w + 2 * f + 6;
    endfunction

endpackage

`default_nettype wire

>>> sv/ofa_step.sv
// One bit of the rounding search, applied to all nine lanes, registered.
// Depends on ofa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ofa_step
    import ofa_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BIT       = 0
)
(
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    input  wire logic                                               en,
    input  wire ofa_ctl_t                                           ctl_in,
    input  wire logic signed [acc_width(IN_WIDTH, FRAC_BITS)-1:0]   d_in   [NLANE],
    input  wire logic signed [acc_width(IN_WIDTH, FRAC_BITS)-1:0]   e_in   [NLANE],
    input  wire logic        [4*IN_WIDTH-1:0]                       s_in   [NLANE],
    input  wire logic        [FRAC_BITS:0]                          k_in   [NLANE],
    input  wire logic                                               neg_in [NLANE],
    output ofa_ctl_t                                                ctl_out,
    output logic signed      [acc_width(IN_WIDTH, FRAC_BITS)-1:0]   d_out  [NLANE],
    output logic signed      [acc_width(IN_WIDTH, FRAC_BITS)-1:0]   e_out  [NLANE],
    output logic             [4*IN_WIDTH-1:0]                       s_out  [NLANE],
    output logic             [FRAC_BITS:0]                          k_out  [NLANE],
    output logic                                                    neg_out[NLANE]
);

    localparam int AW = acc_width(IN_WIDTH, FRAC_BITS);
    localparam int QW = 4 * IN_WIDTH;
    localparam int KW = FRAC_BITS + 1;

    ofa_ctl_t               ctl_reg;
    logic signed [AW-1:0]   d_reg   [NLANE];
    logic signed [AW-1:0]   e_reg   [NLANE];
    logic        [QW-1:0]   s_reg   [NLANE];
    logic        [KW-1:0]   k_reg   [NLANE];
    logic                   neg_reg [NLANE];

    logic signed [AW-1:0]   d_next  [NLANE];
    logic signed [AW-1:0]   e_next  [NLANE];
    logic        [KW-1:0]   k_next  [NLANE];

    // Trial: set this bit of k if the residual stays non-negative.
    // E holds (2k-1)*S, so the added square term is 2^(b+2)*E + 2^(2b+2)*S.
    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            logic signed [AW-1:0] s_ext;
            logic signed [AW-1:0] t;
            logic signed [AW-1:0] nd;
            s_ext = $signed(AW'(s_in[l]));
            t     = (e_in[l] <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
            nd    = d_in[l] - t;
            if (!nd[AW-1])
            begin
                d_next[l] = nd;
                e_next[l] = e_in[l] + (s_ext <<< (BIT + 1));
                k_next[l] = k_in[l] | (KW'(1) << BIT);
            end
            else
            begin
                d_next[l] = d_in[l];
                e_next[l] = e_in[l];
                k_next[l] = k_in[l];
            end
        end
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                d_reg[l]   <= d_next[l];
                e_reg[l]   <= e_next[l];
                s_reg[l]   <= s_in[l];
                k_reg[l]   <= k_next[l];
                neg_reg[l] <= neg_in[l];
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign d_out   = d_reg;
    assign e_out   = e_reg;
    assign s_out   = s_reg;
    assign k_out   = k_reg;
    assign neg_out = neg_reg;

endmodule

`default_nettype wire

>>> sv/orthonormal_frame_from_axis.sv
// Top level of the orthonormal frame block: front-end arithmetic and output stage.
// Depends on ofa_pkg, ofa_step and orthonormal_frame_from_axis_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Takes one signed axis vector per transaction and returns the right-handed
// orthonormal frame (u, v, w) in signed Q1.FRAC_BITS, each component rounded to
// nearest with ties away from zero; a zero axis gives all zeros and degenerate
// high. The block accepts one transaction every clock cycle unless in_stall is
// high. The pipeline holds six stages of squaring, partial products and setup,
// one stage per result bit for the rounding search, and the output register.
// The whole pipeline advances together, so in_stall follows a stalled output
// register.
module orthonormal_frame_from_axis
    import ofa_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [IN_WIDTH-1:0]  axis_x,
    input  wire logic signed [IN_WIDTH-1:0]  axis_y,
    input  wire logic signed [IN_WIDTH-1:0]  axis_z,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [FRAC_BITS+1:0]      u_x,
    output logic signed [FRAC_BITS+1:0]      u_y,
    output logic signed [FRAC_BITS+1:0]      u_z,
    output logic signed [FRAC_BITS+1:0]      v_x,
    output logic signed [FRAC_BITS+1:0]      v_y,
    output logic signed [FRAC_BITS+1:0]      v_z,
    output logic signed [FRAC_BITS+1:0]      w_x,
    output logic signed [FRAC_BITS+1:0]      w_y,
    output logic signed [FRAC_BITS+1:0]      w_z,
    output logic                             degenerate
);

`include "orthonormal_frame_from_axis_macros.svh"

    localparam int W     = IN_WIDTH;
    localparam int PW    = 2 * IN_WIDTH;
    localparam int QW    = 4 * IN_WIDTH;
    localparam int AW    = acc_width(IN_WIDTH, FRAC_BITS);
    localparam int KW    = FRAC_BITS + 1;
    localparam int OW    = FRAC_BITS + 2;
    localparam int NSTEP = FRAC_BITS + 1;
    localparam logic signed [OW-1:0] ONE = OW'(1) << FRAC_BITS;

    // Whole-pipeline advance: hold everything while a result waits.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // ---------------- Stage 1: magnitudes and signs ----------------
    logic        [W-1:0] mag_c [3];
    logic                neg_c [3];
    logic                sel_c;
    logic                zero_c;

    always_comb
    begin
        logic [W-1:0] comp [3];
        comp[0] = axis_x;
        comp[1] = axis_y;
        comp[2] = axis_z;
        for (int i = 0; i < 3; i++)
        begin
            neg_c[i] = comp[i][W-1];
            mag_c[i] = comp[i][W-1] ? (~comp[i] + 1'b1) : comp[i];
        end
        sel_c  = mag_c[0] > mag_c[1];
        zero_c = (mag_c[0] == '0) && (mag_c[1] == '0) && (mag_c[2] == '0);
    end

    ofa_ctl_t     s1_ctl_reg;
    logic [W-1:0] s1_mag_reg [3];
    logic         s1_neg_reg [3];
    logic         s1_sel_reg;

    // ---------------- Stage 2: pairwise products ----------------
    ofa_ctl_t      s2_ctl_reg;
    logic [W-1:0]  s2_mag_reg [3];
    logic          s2_neg_reg [3];
    logic          s2_nz_reg  [3];
    logic          s2_sel_reg;
    logic [PW-1:0] s2_pxx_reg, s2_pyy_reg, s2_pzz_reg;
    logic [PW-1:0] s2_pxy_reg, s2_pxz_reg, s2_pyz_reg;

    // ---------------- Stage 3: lane components and squared lengths ----------------
    ofa_ctl_t      s3_ctl_reg;
    logic [PW-1:0] s3_c_reg   [NLANE];
    logic          s3_neg_reg [NLANE];
    logic [PW-1:0] s3_su_reg;
    logic [PW-1:0] s3_sv_reg;
    logic [PW-1:0] c_next   [NLANE];
    logic          neg_next [NLANE];
    logic [PW-1:0] su_next;
    logic [PW-1:0] sv_next;

    always_comb
    begin
        logic [PW+1:0] su_sum;
        logic [PW:0]   sxz;
        logic [PW:0]   syz;
        su_sum = (PW+2)'(s2_pxx_reg) + (PW+2)'(s2_pyy_reg) + (PW+2)'(s2_pzz_reg);
        sxz    = (PW+1)'(s2_pxx_reg) + (PW+1)'(s2_pzz_reg);
        syz    = (PW+1)'(s2_pyy_reg) + (PW+1)'(s2_pzz_reg);
        su_next = su_sum[PW-1:0];
        // The unit axis lanes.
        for (int i = 0; i < 3; i++)
        begin
            c_next[LANE_UX + i]   = PW'(s2_mag_reg[i]);
            neg_next[LANE_UX + i] = s2_neg_reg[i];
        end
        if (s2_sel_reg)
        begin
            // Helper (-z, 0, x), cross product (xy, -(x^2+z^2), yz).
            sv_next          = sxz[PW-1:0];
            c_next[LANE_VX]  = PW'(s2_mag_reg[2]);
            neg_next[LANE_VX] = s2_nz_reg[2] && !s2_neg_reg[2];
            c_next[LANE_VY]  = '0;
            neg_next[LANE_VY] = 1'b0;
            c_next[LANE_VZ]  = PW'(s2_mag_reg[0]);
            neg_next[LANE_VZ] = s2_neg_reg[0];
            c_next[LANE_WX]  = s2_pxy_reg;
            neg_next[LANE_WX] = s2_neg_reg[0] ^ s2_neg_reg[1];
            c_next[LANE_WY]  = sxz[PW-1:0];
            neg_next[LANE_WY] = 1'b1;
            c_next[LANE_WZ]  = s2_pyz_reg;
            neg_next[LANE_WZ] = s2_neg_reg[1] ^ s2_neg_reg[2];
        end
        else
        begin
            // Helper (0, z, -y), cross product (-(y^2+z^2), xy, xz).
            sv_next          = syz[PW-1:0];
            c_next[LANE_VX]  = '0;
            neg_next[LANE_VX] = 1'b0;
            c_next[LANE_VY]  = PW'(s2_mag_reg[2]);
            neg_next[LANE_VY] = s2_neg_reg[2];
            c_next[LANE_VZ]  = PW'(s2_mag_reg[1]);
            neg_next[LANE_VZ] = s2_nz_reg[1] && !s2_neg_reg[1];
            c_next[LANE_WX]  = syz[PW-1:0];
            neg_next[LANE_WX] = 1'b1;
            c_next[LANE_WY]  = s2_pxy_reg;
            neg_next[LANE_WY] = s2_neg_reg[0] ^ s2_neg_reg[1];
            c_next[LANE_WZ]  = s2_pxz_reg;
            neg_next[LANE_WZ] = s2_neg_reg[0] ^ s2_neg_reg[2];
        end
    end

    // ---------------- Stage 4: half-width partial products ----------------
    ofa_ctl_t      s4_ctl_reg;
    logic [PW-1:0] s4_ll_reg  [NLANE];
    logic [PW-1:0] s4_lh_reg  [NLANE];
    logic [PW-1:0] s4_hh_reg  [NLANE];
    logic          s4_neg_reg [NLANE];
    logic [PW-1:0] s4_su_reg;
    logic [PW-1:0] s4_sv_reg;
    logic [PW-1:0] s4_wll_reg, s4_wlh_reg, s4_whl_reg, s4_whh_reg;

    // ---------------- Stage 5: full squares ----------------
    ofa_ctl_t      s5_ctl_reg;
    logic [QW-1:0] s5_sq_reg  [NLANE];
    logic [QW-1:0] s5_s_reg   [NLANE];
    logic          s5_neg_reg [NLANE];
    logic [QW-1:0] sq_next    [NLANE];
    logic [QW-1:0] s_next     [NLANE];

    always_comb
    begin
        logic [QW-1:0] sw;
        sw = (QW'(s4_whh_reg) << PW)
           + ((QW'(s4_whl_reg) + QW'(s4_wlh_reg)) << W)
           + QW'(s4_wll_reg);
        for (int l = 0; l < NLANE; l++)
        begin
            sq_next[l] = (QW'(s4_hh_reg[l]) << PW)
                       + (QW'(s4_lh_reg[l]) << (W + 1))
                       + QW'(s4_ll_reg[l]);
            if (l <= LANE_UZ)
            begin
                s_next[l] = QW'(s4_su_reg);
            end
            else if (l <= LANE_VZ)
            begin
                s_next[l] = QW'(s4_sv_reg);
            end
            else
            begin
                s_next[l] = sw;
            end
        end
    end

    // ---------------- Stage 6: search setup ----------------
    ofa_ctl_t             st_ctl [NSTEP+1];
    logic signed [AW-1:0] st_d   [NSTEP+1][NLANE];
    logic signed [AW-1:0] st_e   [NSTEP+1][NLANE];
    logic        [QW-1:0] st_s   [NSTEP+1][NLANE];
    logic        [KW-1:0] st_k   [NSTEP+1][NLANE];
    logic                 st_neg [NSTEP+1][NLANE];

    ofa_ctl_t             s6_ctl_reg;
    logic signed [AW-1:0] s6_d_reg   [NLANE];
    logic signed [AW-1:0] s6_e_reg   [NLANE];
    logic        [QW-1:0] s6_s_reg   [NLANE];
    logic                 s6_neg_reg [NLANE];

    // Control registers of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            s6_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg <= '{valid: in_valid, zero: zero_c};
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            s5_ctl_reg <= s4_ctl_reg;
            s6_ctl_reg <= s5_ctl_reg;
        end
    end

    // Payload registers of the front stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1.
            for (int i = 0; i < 3; i++)
            begin
                s1_mag_reg[i] <= mag_c[i];
                s1_neg_reg[i] <= neg_c[i];
            end
            s1_sel_reg <= sel_c;
            // Stage 2.
            for (int i = 0; i < 3; i++)
            begin
                s2_mag_reg[i] <= s1_mag_reg[i];
                s2_neg_reg[i] <= s1_neg_reg[i];
                s2_nz_reg[i]  <= s1_mag_reg[i] != '0;
            end
            s2_sel_reg <= s1_sel_reg;
            s2_pxx_reg <= s1_mag_reg[0] * s1_mag_reg[0];
            s2_pyy_reg <= s1_mag_reg[1] * s1_mag_reg[1];
            s2_pzz_reg <= s1_mag_reg[2] * s1_mag_reg[2];
            s2_pxy_reg <= s1_mag_reg[0] * s1_mag_reg[1];
            s2_pxz_reg <= s1_mag_reg[0] * s1_mag_reg[2];
            s2_pyz_reg <= s1_mag_reg[1] * s1_mag_reg[2];
            // Stage 3.
            for (int l = 0; l < NLANE; l++)
            begin
                s3_c_reg[l]   <= c_next[l];
                s3_neg_reg[l] <= neg_next[l];
            end
            s3_su_reg <= su_next;
            s3_sv_reg <= sv_next;
            // Stage 4.
            for (int l = 0; l < NLANE; l++)
            begin
                s4_ll_reg[l]  <= s3_c_reg[l][W-1:0] * s3_c_reg[l][W-1:0];
                s4_lh_reg[l]  <= s3_c_reg[l][W-1:0] * s3_c_reg[l][PW-1:W];
                s4_hh_reg[l]  <= s3_c_reg[l][PW-1:W] * s3_c_reg[l][PW-1:W];
                s4_neg_reg[l] <= s3_neg_reg[l];
            end
            s4_su_reg  <= s3_su_reg;
            s4_sv_reg  <= s3_sv_reg;
            s4_wll_reg <= s3_su_reg[W-1:0] * s3_sv_reg[W-1:0];
            s4_wlh_reg <= s3_su_reg[W-1:0] * s3_sv_reg[PW-1:W];
            s4_whl_reg <= s3_su_reg[PW-1:W] * s3_sv_reg[W-1:0];
            s4_whh_reg <= s3_su_reg[PW-1:W] * s3_sv_reg[PW-1:W];
            // Stage 5.
            for (int l = 0; l < NLANE; l++)
            begin
                s5_sq_reg[l]  <= sq_next[l];
                s5_s_reg[l]   <= s_next[l];
                s5_neg_reg[l] <= s4_neg_reg[l];
            end
            // Stage 6: residual starts at 4*c^2*2^(2F) - S, and E at -S.
            for (int l = 0; l < NLANE; l++)
            begin
                s6_d_reg[l]   <= ($signed(AW'(s5_sq_reg[l])) <<< (2 * FRAC_BITS + 2))
                               - $signed(AW'(s5_s_reg[l]));
                s6_e_reg[l]   <= -$signed(AW'(s5_s_reg[l]));
                s6_s_reg[l]   <= s5_s_reg[l];
                s6_neg_reg[l] <= s5_neg_reg[l];
            end
        end
    end

    assign st_ctl[0] = s6_ctl_reg;
    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            st_d[0][l]   = s6_d_reg[l];
            st_e[0][l]   = s6_e_reg[l];
            st_s[0][l]   = s6_s_reg[l];
            st_k[0][l]   = '0;
            st_neg[0][l] = s6_neg_reg[l];
        end
    end

    // ---------------- Rounding search, most significant bit first ----------------
    for (genvar g = 0; g < NSTEP; g++)
    begin : g_step
        ofa_step #(
            .IN_WIDTH  (IN_WIDTH),
            .FRAC_BITS (FRAC_BITS),
            .BIT       (FRAC_BITS - g)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .ctl_in  (st_ctl[g]),
            .d_in    (st_d[g]),
            .e_in    (st_e[g]),
            .s_in    (st_s[g]),
            .k_in    (st_k[g]),
            .neg_in  (st_neg[g]),
            .ctl_out (st_ctl[g+1]),
            .d_out   (st_d[g+1]),
            .e_out   (st_e[g+1]),
            .s_out   (st_s[g+1]),
            .k_out   (st_k[g+1]),
            .neg_out (st_neg[g+1])
        );
    end

    // ---------------- Output register ----------------
    logic                 out_valid_reg;
    logic                 degenerate_reg;
    logic signed [OW-1:0] res_reg  [NLANE];
    logic signed [OW-1:0] res_next [NLANE];

    // Apply the sign; a zero axis forces every component to zero.
    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            logic [OW-1:0] kv;
            kv = OW'(st_k[NSTEP][l]);
            if (st_ctl[NSTEP].zero)
            begin
                res_next[l] = '0;
            end
            else if (st_neg[NSTEP][l])
            begin
                res_next[l] = $signed(OW'(0) - kv);
            end
            else
            begin
                res_next[l] = $signed(kv);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= st_ctl[NSTEP].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            degenerate_reg <= st_ctl[NSTEP].zero;
            for (int l = 0; l < NLANE; l++)
            begin
                res_reg[l] <= res_next[l];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign degenerate = degenerate_reg;
    assign u_x = res_reg[LANE_UX];
    assign u_y = res_reg[LANE_UY];
    assign u_z = res_reg[LANE_UZ];
    assign v_x = res_reg[LANE_VX];
    assign v_y = res_reg[LANE_VY];
    assign v_z = res_reg[LANE_VZ];
    assign w_x = res_reg[LANE_WX];
    assign w_y = res_reg[LANE_WY];
    assign w_z = res_reg[LANE_WZ];

    // ---------------- Assertions ----------------
    `OFA_ASSERT_IMPL(a_degen_zero, clk, rst_n, out_valid && degenerate,
        u_x == 0 && u_y == 0 && u_z == 0 && v_x == 0 && v_y == 0 && v_z == 0
        && w_x == 0 && w_y == 0 && w_z == 0,
        "degenerate transaction with nonzero frame")
    `OFA_ASSERT_IMPL(a_frame_nonzero, clk, rst_n, out_valid && !degenerate,
        (u_x != 0 || u_y != 0 || u_z != 0) && (v_x != 0 || v_y != 0 || v_z != 0)
        && (w_x != 0 || w_y != 0 || w_z != 0),
        "frame vector rounded to zero")
    `OFA_ASSERT_IMPL(a_unit_range, clk, rst_n, out_valid,
        u_x <= ONE && u_x >= -ONE && v_y <= ONE && v_y >= -ONE
        && w_z <= ONE && w_z >= -ONE,
        "component outside unit range")

endmodule

`default_nettype wire
